[sv/ata_pio_lba28_command_sequencer_macros.svh]
// assertion macros for the sequencer rtl, used by ata_seq_emit
// expects clk and arst_n in the scope of the caller
`ifndef ATA_PIO_LBA28_COMMAND_SEQUENCER_MACROS_SVH
`define ATA_PIO_LBA28_COMMAND_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ATA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ATA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ATA_ASSERT_IMP(lbl, ante, cons)
`define ATA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/ata_seq_pkg.sv]
// types, codes and constants of the ata pio lba28 command sequencer
// no dependencies
package ata_seq_pkg;

	localparam int DRIVE_COUNT = 4;
	localparam int DRV_IDX_W   = 2;
	localparam int BURST_MAX   = 8;
	localparam int BURST_CNT_W = 4;
	localparam int LBA_W       = 28;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 16;

	localparam logic [7:0] DEVSEL_BASE = 8'hE0;
	localparam logic [7:0] CTRL_NO_INT = 8'h02;
	localparam logic [7:0] CMD_READ    = 8'h20;
	localparam logic [7:0] CMD_WRITE   = 8'h30;

	localparam int ST_BUSY  = 7;
	localparam int ST_FAULT = 5;
	localparam int ST_DRQ   = 3;
	localparam int ST_ERR   = 0;

	typedef enum logic [2:0] {
		KIND_WRITE  = 3'd0,
		KIND_STATUS = 3'd1,
		KIND_XFER   = 3'd2,
		KIND_SETTLE = 3'd3,
		KIND_DONE   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_CONTROL = 3'd0,
		REG_DEVSEL  = 3'd1,
		REG_COUNT   = 3'd2,
		REG_LBA_LO  = 3'd3,
		REG_LBA_MID = 3'd4,
		REG_LBA_HI  = 3'd5,
		REG_COMMAND = 3'd6
	} reg_t;

	typedef enum logic [2:0] {
		RES_OK        = 3'd0,
		RES_BAD_DRIVE = 3'd1,
		RES_NO_LBA    = 3'd2,
		RES_BOUNDS    = 3'd3,
		RES_ERROR     = 3'd4,
		RES_FAULT     = 3'd5,
		RES_NO_DRQ    = 3'd6
	} code_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_READY  = 2'd1,
		PH_SECTOR = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CFG_PRESENT = 2'd0,
		CFG_LBA_CAP = 2'd1,
		CFG_CHANNEL = 2'd2,
		CFG_UNIT    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		kind_t      kind;
		logic       channel_sel;
		reg_t       reg_sel;
		logic [7:0] write_value;
		code_t      result_code;
		logic       last;
	} result_t;

	typedef result_t [BURST_MAX-1:0] burst_t;

	typedef struct packed {
		burst_t                 words;
		logic [BURST_CNT_W-1:0] count;
	} burst_load_t;

	function automatic result_t mk_word(kind_t k, logic ch, reg_t r, logic [7:0] v,
		code_t c);
		result_t w;
		w.kind        = k;
		w.channel_sel = ch;
		w.reg_sel     = r;
		w.write_value = v;
		w.result_code = c;
		w.last        = 1'b0;
		return w;
	endfunction

endpackage

[sv/ata_seq_core.sv]
// request check, sequencing state and burst build for one input word
// depends on ata_seq_pkg
module ata_seq_core
	import ata_seq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [3:0]             cfg_wdata,
	input  logic                   accept,
	input  logic                   action,
	input  logic                   is_write,
	input  logic [7:0]             drive_number,
	input  logic [31:0]            block_address,
	input  logic [7:0]             sector_total,
	input  logic [7:0]             status_byte,
	output burst_load_t            burst
);

	logic [3:0] present_q, lba_cap_q, channel_q, unit_q;

	phase_t             phase_q, phase_d;
	logic               chan_q;
	logic               op_write_q;
	logic [7:0]         left_q;
	logic [7:0]         count_q;
	logic [LBA_W-1:0]   lba_q;
	logic [7:0]         devsel_q;

	logic [DRV_IDX_W-1:0] d_idx;
	logic                 in_range;
	code_t                req_code;
	logic [7:0]           left_dec;
	code_t                sec_code;
	logic                 req_ok;
	logic                 sec_step;

	burst_t                 w;
	logic [BURST_CNT_W-1:0] n;

	assign d_idx    = drive_number[DRV_IDX_W-1:0];
	assign in_range = drive_number < 8'(DRIVE_COUNT);
	assign left_dec = left_q - 8'd1;

	always_comb begin
		if (!in_range || !present_q[d_idx]) begin
			req_code = RES_BAD_DRIVE;
		end else if (!lba_cap_q[d_idx]) begin
			req_code = RES_NO_LBA;
		end else if (block_address[31:LBA_W] != '0) begin
			req_code = RES_BOUNDS;
		end else begin
			req_code = RES_OK;
		end
	end

	always_comb begin
		if (status_byte[ST_ERR]) begin
			sec_code = RES_ERROR;
		end else if (status_byte[ST_FAULT]) begin
			sec_code = RES_FAULT;
		end else if (!status_byte[ST_DRQ]) begin
			sec_code = RES_NO_DRQ;
		end else begin
			sec_code = RES_OK;
		end
	end

	assign req_ok   = !action && (req_code == RES_OK);
	assign sec_step = action && (phase_q == PH_SECTOR) && !status_byte[ST_BUSY];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (!action) begin
			if (req_code == RES_OK) begin
				phase_d = PH_READY;
			end
		end else if (!status_byte[ST_BUSY]) begin
			case (phase_q)
				PH_READY:  phase_d = (left_q == '0) ? PH_IDLE : PH_SECTOR;
				PH_SECTOR: begin
					if (sec_code != RES_OK || left_dec == '0) begin
						phase_d = PH_IDLE;
					end
				end
				default:   phase_d = phase_q;
			endcase
		end
	end

	// result words
	always_comb begin
		w = '0;
		n = '0;
		if (!action) begin
			if (req_code != RES_OK) begin
				w[0] = mk_word(KIND_DONE, 1'b0, REG_CONTROL, 8'h00, req_code);
				n    = 4'd1;
			end else begin
				w[0] = mk_word(KIND_WRITE, channel_q[d_idx], REG_CONTROL, CTRL_NO_INT,
					RES_OK);
				w[1] = mk_word(KIND_STATUS, channel_q[d_idx], REG_CONTROL, 8'h00, RES_OK);
				n    = 4'd2;
			end
		end else if (phase_q == PH_READY || phase_q == PH_SECTOR) begin
			if (status_byte[ST_BUSY]) begin
				w[0] = mk_word(KIND_STATUS, chan_q, REG_CONTROL, 8'h00, RES_OK);
				n    = 4'd1;
			end else if (phase_q == PH_READY) begin
				w[0] = mk_word(KIND_WRITE, chan_q, REG_DEVSEL, devsel_q, RES_OK);
				w[1] = mk_word(KIND_WRITE, chan_q, REG_COUNT, count_q, RES_OK);
				w[2] = mk_word(KIND_WRITE, chan_q, REG_LBA_LO, lba_q[7:0], RES_OK);
				w[3] = mk_word(KIND_WRITE, chan_q, REG_LBA_MID, lba_q[15:8], RES_OK);
				w[4] = mk_word(KIND_WRITE, chan_q, REG_LBA_HI, lba_q[23:16], RES_OK);
				w[5] = mk_word(KIND_WRITE, chan_q, REG_COMMAND,
					op_write_q ? CMD_WRITE : CMD_READ, RES_OK);
				if (left_q == '0) begin
					w[6] = mk_word(KIND_DONE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd7;
				end else begin
					w[6] = mk_word(KIND_SETTLE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					w[7] = mk_word(KIND_STATUS, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd8;
				end
			end else if (sec_code != RES_OK) begin
				w[0] = mk_word(KIND_DONE, chan_q, REG_CONTROL, 8'h00, sec_code);
				n    = 4'd1;
			end else if (op_write_q) begin
				if (left_dec == '0) begin
					w[0] = mk_word(KIND_DONE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd1;
				end else begin
					w[0] = mk_word(KIND_SETTLE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					w[1] = mk_word(KIND_STATUS, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd2;
				end
			end else begin
				w[0] = mk_word(KIND_XFER, chan_q, REG_CONTROL, 8'h00, RES_OK);
				if (left_dec == '0) begin
					w[1] = mk_word(KIND_DONE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd2;
				end else begin
					w[1] = mk_word(KIND_SETTLE, chan_q, REG_CONTROL, 8'h00, RES_OK);
					w[2] = mk_word(KIND_STATUS, chan_q, REG_CONTROL, 8'h00, RES_OK);
					n    = 4'd3;
				end
			end
		end
		for (int i = 0; i < BURST_MAX; i++) begin
			w[i].last = (BURST_CNT_W'(i + 1) == n);
		end
	end

	assign burst.words = w;
	assign burst.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			lba_cap_q <= '0;
			channel_q <= '0;
			unit_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_PRESENT: present_q <= cfg_wdata;
				CFG_LBA_CAP: lba_cap_q <= cfg_wdata;
				CFG_CHANNEL: channel_q <= cfg_wdata;
				CFG_UNIT:    unit_q    <= cfg_wdata;
				default:     present_q <= present_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			chan_q     <= 1'b0;
			op_write_q <= 1'b0;
			left_q     <= '0;
			count_q    <= '0;
			lba_q      <= '0;
			devsel_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (req_ok) begin
				chan_q     <= channel_q[d_idx];
				op_write_q <= is_write;
				left_q     <= sector_total;
				count_q    <= sector_total;
				lba_q      <= block_address[LBA_W-1:0];
				devsel_q   <= DEVSEL_BASE | {3'b000, unit_q[d_idx], block_address[27:24]};
			end else if (sec_step && sec_code == RES_OK) begin
				left_q <= left_dec;
			end
		end
	end

endmodule

[sv/ata_seq_emit.sv]
// result word buffer: takes a whole burst and hands it out one word a cycle while word_ready is high
// depends on ata_seq_pkg and the assertion macro header
`include "ata_pio_lba28_command_sequencer_macros.svh"
module ata_seq_emit
	import ata_seq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  burst_load_t burst,
	input  logic        load,
	output logic        can_load,
	output logic        word_valid,
	input  logic        word_ready,
	output result_t     word
);

	burst_t                 buf_q;
	logic [BURST_CNT_W-1:0] rem_q;
	logic                   take;

	assign word_valid = (rem_q != '0);
	assign word       = buf_q[0];
	assign take       = word_valid && word_ready;
	assign can_load   = (rem_q == '0) || ((rem_q == BURST_CNT_W'(1)) && word_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= burst.count;
		end else if (take) begin
			rem_q <= rem_q - BURST_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.words;
		end else if (take) begin
			for (int i = 0; i < BURST_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[BURST_MAX-1] <= '0;
		end
	end

	`ATA_ASSERT_IMP(a_rem_bound, 1'b1, rem_q <= BURST_CNT_W'(BURST_MAX))
	`ATA_ASSERT_IMP(a_last_on_final, word_valid, word.last == (rem_q == BURST_CNT_W'(1)))
	`ATA_ASSERT_IMP(a_load_when_free, load, can_load)
	`ATA_ASSERT_NEXT(a_drain_empty, take && !load && rem_q == BURST_CNT_W'(1), rem_q == '0)

endmodule

[sv/ata_pio_lba28_command_sequencer.sv]
// top level of the ata pio lba28 command sequencer: stream ports and config port
// depends on ata_seq_pkg, ata_seq_core and ata_seq_emit
//
// Each accepted input word (a request, or a status byte from the device) is
// checked and turned into a burst of zero to eight result words in the cycle it
// is accepted. The burst is held in a result buffer and handed out at one word
// per cycle while m_tready is high; the next input word is taken in the same
// cycle the final result word leaves, or at once when the previous word caused
// none. The output word buffer sets the rate. Drive tables are to be written
// through the cfg port only while idle; the block itself does not enforce it.
module ata_pio_lba28_command_sequencer
	import ata_seq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [3:0]            cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// is_write, drive_number, block_address, sector_total, status_byte, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// channel_sel, reg_sel, write_value, result_code, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// kind
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	burst_load_t burst;
	logic        accept;
	result_t     word;

	assign accept = s_tvalid && s_tready;

	ata_seq_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.action        (s_tuser),
		.is_write      (s_tdata[0]),
		.drive_number  (s_tdata[8:1]),
		.block_address (s_tdata[40:9]),
		.sector_total  (s_tdata[48:41]),
		.status_byte   (s_tdata[56:49]),
		.burst         (burst)
	);

	ata_seq_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst      (burst),
		.load       (accept),
		.can_load   (s_tready),
		.word_valid (m_tvalid),
		.word_ready (m_tready),
		.word       (word)
	);

	assign m_tdata = {1'b0, word.result_code, word.write_value, word.reg_sel, word.channel_sel};
	assign m_tuser = word.kind;
	assign m_tlast = word.last;

endmodule
